// ===== sv/ctn_pkg.sv =====
// Package for the chat text normalizer: constants, byte codes and the queue entry type.
`timescale 1ns / 1ps

package ctn_pkg;

    // Default width of the per-message character counter
    localparam int LENGTH_BITS = 16;
    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Reset value of the output length limit
    localparam logic [15:0] LIMIT_RESET = 16'd255;

    // UTF-8 smart quote byte codes
    localparam logic [7:0] BYTE_E2   = 8'hE2;
    localparam logic [7:0] BYTE_80   = 8'h80;
    localparam logic [7:0] SQ_LEFT   = 8'h98;
    localparam logic [7:0] SQ_RIGHT  = 8'h99;
    localparam logic [7:0] DQ_LEFT   = 8'h9C;
    localparam logic [7:0] DQ_RIGHT  = 8'h9D;

    // ASCII codes used by the classifier
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
    localparam logic [7:0] BYTE_LOWER_A = 8'h61;
    localparam logic [7:0] BYTE_LOWER_Z = 8'h7A;
    localparam logic [7:0] BYTE_DIGIT_0 = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_9 = 8'h39;
    localparam logic [7:0] BYTE_APOS    = 8'h27;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_APOS  = 7'h27;

    // One queue entry: up to a space plus a character, or a terminator
    typedef struct packed {
        logic        emit_space;
        logic        emit_char;
        logic [6:0]  ch;
        logic        term;
        logic [15:0] length;
    } entry_t;

endpackage

// ===== sv/ctn_front.sv =====
// Front end: accepts transactions, decodes smart quotes, collapses whitespace, applies the limit.
`timescale 1ns / 1ps

module ctn_front #(
    parameter int LENGTH_BITS = ctn_pkg::LENGTH_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [7:0]        in_byte,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data,
    input  logic              q_full,
    output logic              push,
    output ctn_pkg::entry_t   push_entry
);

    localparam int W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    typedef enum logic [1:0] {
        Q_NONE,
        Q_E2,
        Q_E280
    } quote_t;

    quote_t                 quote_stage_reg, quote_stage_next;
    logic                   space_pending_reg, space_pending_next;
    logic                   any_emitted_reg, any_emitted_next;
    logic [LENGTH_BITS-1:0] emit_count_reg, emit_count_next;
    logic [15:0]            out_limit_reg;

    logic                   accept;
    logic [W-1:0]           count_w, count_inc_w, limit_w;
    logic [LENGTH_BITS-1:0] count_inc;
    logic                   fit0, fit1;
    logic [7:0]             lower;
    logic                   keep_class, is_sq, is_dq, is_e2;
    logic                   sp_eff, do_plain, do_apos, keep, sp;
    logic                   emit_space, emit_char;
    logic [6:0]             ch;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Limit checks for the current count and the count after one more character
    always_comb
    begin
        count_inc   = emit_count_reg + 1'b1;
        count_w     = W'(emit_count_reg);
        count_inc_w = W'(count_inc);
        limit_w     = W'(out_limit_reg);
        fit0        = (count_w < limit_w) && (emit_count_reg != '1);
        fit1        = (count_inc_w < limit_w) && (count_inc != '1);
    end

    // Byte classification
    always_comb
    begin
        if (in_byte >= ctn_pkg::BYTE_UPPER_A && in_byte <= ctn_pkg::BYTE_UPPER_Z)
            lower = in_byte + ctn_pkg::CASE_OFFSET;
        else
            lower = in_byte;
        keep_class = (lower >= ctn_pkg::BYTE_LOWER_A && lower <= ctn_pkg::BYTE_LOWER_Z)
                  || (lower >= ctn_pkg::BYTE_DIGIT_0 && lower <= ctn_pkg::BYTE_DIGIT_9)
                  || (lower == ctn_pkg::BYTE_APOS);
        is_sq = (in_byte == ctn_pkg::SQ_LEFT) || (in_byte == ctn_pkg::SQ_RIGHT);
        is_dq = (in_byte == ctn_pkg::DQ_LEFT) || (in_byte == ctn_pkg::DQ_RIGHT);
        is_e2 = (in_byte == ctn_pkg::BYTE_E2);
    end

    // Next state and queue entry
    always_comb
    begin
        quote_stage_next   = quote_stage_reg;
        space_pending_next = space_pending_reg;
        any_emitted_next   = any_emitted_reg;
        emit_count_next    = emit_count_reg;
        push               = 1'b0;
        push_entry         = '0;
        sp_eff             = space_pending_reg;
        do_plain           = 1'b0;
        do_apos            = 1'b0;
        keep               = 1'b0;
        sp                 = 1'b0;
        emit_space         = 1'b0;
        emit_char          = 1'b0;
        ch                 = lower[6:0];

        if (accept)
        begin
            if (kind)
            begin
                // End of message: terminator carries the count, message state clears
                push              = 1'b1;
                push_entry.term   = 1'b1;
                push_entry.length = count_w[15:0];
                quote_stage_next   = Q_NONE;
                space_pending_next = 1'b0;
                any_emitted_next   = 1'b0;
                emit_count_next    = '0;
            end
            else
            begin
                unique case (quote_stage_reg)
                    Q_E280:
                    begin
                        quote_stage_next = Q_NONE;
                        if (is_sq)
                            do_apos = 1'b1;
                        else
                        begin
                            sp_eff   = 1'b1;
                            do_plain = !is_dq;
                        end
                    end
                    Q_E2:
                    begin
                        if (in_byte == ctn_pkg::BYTE_80)
                            quote_stage_next = Q_E280;
                        else
                        begin
                            quote_stage_next = Q_NONE;
                            sp_eff           = 1'b1;
                            do_plain         = 1'b1;
                        end
                    end
                    default:
                    begin
                        quote_stage_next = Q_NONE;
                        do_plain         = 1'b1;
                    end
                endcase

                space_pending_next = sp_eff;
                keep = do_apos || (do_plain && !is_e2 && keep_class);
                if (do_apos)
                    ch = ctn_pkg::CHAR_APOS;

                // A new prefix starts, or the byte counts as whitespace
                if (do_plain && is_e2)
                    quote_stage_next = Q_E2;
                else if (do_plain && !keep_class)
                    space_pending_next = 1'b1;

                // Kept character, with a pending space ahead of it when one is owed
                if (keep)
                begin
                    sp         = any_emitted_reg && sp_eff;
                    emit_space = sp && fit0;
                    emit_char  = sp ? (fit0 && fit1) : fit0;
                    emit_count_next = emit_count_reg + LENGTH_BITS'(emit_space)
                                    + LENGTH_BITS'(emit_char);
                    any_emitted_next   = 1'b1;
                    space_pending_next = 1'b0;
                    push                  = emit_space || emit_char;
                    push_entry.emit_space = emit_space;
                    push_entry.emit_char  = emit_char;
                    push_entry.ch         = ch;
                end
            end
        end
    end

    // State registers and the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_stage_reg   <= Q_NONE;
            space_pending_reg <= 1'b0;
            any_emitted_reg   <= 1'b0;
            emit_count_reg    <= '0;
            out_limit_reg     <= ctn_pkg::LIMIT_RESET;
        end
        else
        begin
            quote_stage_reg   <= quote_stage_next;
            space_pending_reg <= space_pending_next;
            any_emitted_reg   <= any_emitted_next;
            emit_count_reg    <= emit_count_next;
            if (cfg_we)
                out_limit_reg <= cfg_data;
        end
    end

endmodule

// ===== sv/ctn_back.sv =====
// Back end: entry queue and output register, expanding each entry into its result transactions.
`timescale 1ns / 1ps

module ctn_back #(
    parameter int QUEUE_DEPTH = ctn_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctn_pkg::entry_t   push_entry,
    output logic              q_full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [6:0]        out_char,
    output logic              is_char,
    output logic              last,
    output logic [15:0]       out_length
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    ctn_pkg::entry_t   q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              phase_reg;

    logic              out_valid_reg;
    logic [6:0]        out_char_reg;
    logic              is_char_reg;
    logic              last_reg;
    logic [15:0]       out_length_reg;

    ctn_pkg::entry_t   head;
    logic              empty, load, send_space, pop;

    assign q_full     = (count_reg == CNT_FULL);
    assign empty      = (count_reg == '0);
    assign head       = q_mem[rd_ptr_reg];
    assign load       = !empty && (!out_valid_reg || !out_stall);
    assign send_space = head.emit_space && !phase_reg;
    assign pop        = load && !(send_space && head.emit_char);

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign is_char    = is_char_reg;
    assign last       = last_reg;
    assign out_length = out_length_reg;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_entry;
    end

    // Queue pointers, fill count and expansion phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
            if (pop)
                phase_reg <= 1'b0;
            else if (load)
                phase_reg <= 1'b1;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (head.term)
            begin
                out_char_reg   <= '0;
                is_char_reg    <= 1'b0;
                last_reg       <= 1'b1;
                out_length_reg <= head.length;
            end
            else
            begin
                out_char_reg   <= send_space ? ctn_pkg::CHAR_SPACE : head.ch;
                is_char_reg    <= 1'b1;
                last_reg       <= 1'b0;
                out_length_reg <= '0;
            end
        end
    end

endmodule

// ===== sv/chat_text_normalizer.sv =====
// Top level of the chat text normalizer: front end, entry queue and output stage.
// An accepted input passes through the queue and then the output register to reach the outputs.
// Throughput: one input transaction per cycle while the queue is not full; the back end sends one
// result per cycle while out_stall is low, so a space plus a character from one input is two results.
// The queue (QUEUE_DEPTH entries) absorbs those bursts; the front stalls only when it is full.
// Reset: asynchronous, clears message state, queue and output valid; out_limit returns to 255.
`timescale 1ns / 1ps

module chat_text_normalizer #(
    parameter int LENGTH_BITS = ctn_pkg::LENGTH_BITS,
    parameter int QUEUE_DEPTH = ctn_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  in_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_char,
    output logic        is_char,
    output logic        last,
    output logic [15:0] out_length
);

    logic            q_full;
    logic            push;
    ctn_pkg::entry_t push_entry;

    ctn_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .in_byte    (in_byte),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ctn_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .is_char    (is_char),
        .last       (last),
        .out_length (out_length)
    );

endmodule

// ===== verif/ctn_tb_pkg.sv =====
// Shared testbench codes for the chat text normalizer verification environment.
`timescale 1ns / 1ps

package ctn_tb_pkg;

    // Input transaction kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

endpackage

// ===== verif/chat_text_normalizer_checker.sv =====
// Checker for the chat text normalizer: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module chat_text_normalizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  in_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  out_char,
    input  logic        is_char,
    input  logic        last,
    input  logic [15:0] out_length,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [6:0]  ch;
        logic        is_char;
        logic        last;
        logic [15:0] length;
    } norm_item_t;

    // UTF-8 prefix tracking
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_E2,
        PFX_E2_80
    } prefix_t;

    norm_item_t  expected_chars[$];
    norm_item_t  oldest;
    logic [15:0] char_limit;
    prefix_t     prefix;
    logic        space_pending;
    logic        seen_kept;
    logic [15:0] emitted;

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // Emit one character unless the per-message limit is used up
    task automatic push_char(logic [6:0] c);
        norm_item_t item;
        if (emitted < char_limit)
        begin
            item.ch      = c;
            item.is_char = 1'b1;
            item.last    = 1'b0;
            item.length  = 16'd0;
            expected_chars.push_back(item);
            emitted++;
        end
    endtask

    // A kept character flushes a pending separator first, but never a leading one
    task automatic keep_char(logic [6:0] c);
        if (seen_kept && space_pending)
            push_char(ctn_pkg::CHAR_SPACE);
        push_char(c);
        seen_kept     = 1'b1;
        space_pending = 1'b0;
    endtask

    task automatic plain_byte(logic [7:0] b);
        logic [7:0] v;
        if (b == ctn_pkg::BYTE_E2)
            prefix = PFX_E2;
        else
        begin
            v = b;
            if (v >= ctn_pkg::BYTE_UPPER_A && v <= ctn_pkg::BYTE_UPPER_Z)
                v = v + ctn_pkg::CASE_OFFSET;
            if ((v >= ctn_pkg::BYTE_LOWER_A && v <= ctn_pkg::BYTE_LOWER_Z) ||
                (v >= ctn_pkg::BYTE_DIGIT_0 && v <= ctn_pkg::BYTE_DIGIT_9) ||
                v == ctn_pkg::BYTE_APOS)
                keep_char(v[6:0]);
            else
                space_pending = 1'b1;
        end
    endtask

    task automatic predict_byte(logic [7:0] b);
        case (prefix)
            PFX_E2_80:
            begin
                prefix = PFX_NONE;
                if (b == ctn_pkg::SQ_LEFT || b == ctn_pkg::SQ_RIGHT)
                    keep_char(ctn_pkg::CHAR_APOS);
                else
                begin
                    // double quotes and broken sequences act as whitespace
                    space_pending = 1'b1;
                    if (b != ctn_pkg::DQ_LEFT && b != ctn_pkg::DQ_RIGHT)
                        plain_byte(b);
                end
            end
            PFX_E2:
            begin
                if (b == ctn_pkg::BYTE_80)
                    prefix = PFX_E2_80;
                else
                begin
                    prefix        = PFX_NONE;
                    space_pending = 1'b1;
                    plain_byte(b);
                end
            end
            default:
                plain_byte(b);
        endcase
    endtask

    // End of message: terminator with the count, then clear message state
    task automatic predict_end();
        norm_item_t item;
        item.ch      = 7'd0;
        item.is_char = 1'b0;
        item.last    = 1'b1;
        item.length  = emitted;
        expected_chars.push_back(item);
        prefix        = PFX_NONE;
        space_pending = 1'b0;
        seen_kept     = 1'b0;
        emitted       = 16'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            char_limit    = ctn_pkg::LIMIT_RESET;
            prefix        = PFX_NONE;
            space_pending = 1'b0;
            seen_kept     = 1'b0;
            emitted       = 16'd0;
            fail_count    = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
                char_limit = cfg_data;

            // Predict from the accepted input transaction
            if (in_valid && !in_stall)
            begin
                if (kind == ctn_tb_pkg::KIND_END)
                    predict_end();
                else
                    predict_byte(in_byte);
            end

            // Compare the accepted result transaction with the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch("unexpected result, out_char", 16'(out_char), 16'd0);
                else
                begin
                    oldest = expected_chars.pop_front();
                    if (out_char !== oldest.ch)
                        report_mismatch("out_char", 16'(out_char), 16'(oldest.ch));
                    if (is_char !== oldest.is_char)
                        report_mismatch("is_char", 16'(is_char), 16'(oldest.is_char));
                    if (last !== oldest.last)
                        report_mismatch("last", 16'(last), 16'(oldest.last));
                    if (out_length !== oldest.length)
                        report_mismatch("out_length", out_length, oldest.length);
                end
            end

            pending <= expected_chars.size();
        end
    end

endmodule

// ===== verif/chat_text_normalizer_tb.sv =====
// Testbench top for the chat text normalizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module chat_text_normalizer_tb;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 80;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        kind       = ctn_tb_pkg::KIND_BYTE;
    logic [7:0]  in_byte    = 8'd0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_data   = 16'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [6:0]  out_char;
    logic        is_char;
    logic        last;
    logic [15:0] out_length;

    int fail_count;
    int pending;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int cycle_count;
    logic hold_request = 1'b0;

    chat_text_normalizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .in_byte    (in_byte),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .is_char    (is_char),
        .last       (last),
        .out_length (out_length)
    );

    chat_text_normalizer_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .in_byte    (in_byte),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .is_char    (is_char),
        .last       (last),
        .out_length (out_length),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request)
        begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Offer one transaction after a random gap and wait for it to be taken
    task automatic send_item(logic k, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Stop offering and let every expected result come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One random token: word characters, separators, smart quotes, broken prefixes, noise
    task automatic send_token();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            send_item(ctn_tb_pkg::KIND_BYTE,
                      8'($urandom_range(ctn_pkg::BYTE_LOWER_A, ctn_pkg::BYTE_LOWER_Z)));
        else if (roll < 47)
            send_item(ctn_tb_pkg::KIND_BYTE,
                      8'($urandom_range(ctn_pkg::BYTE_UPPER_A, ctn_pkg::BYTE_UPPER_Z)));
        else if (roll < 55)
            send_item(ctn_tb_pkg::KIND_BYTE,
                      8'($urandom_range(ctn_pkg::BYTE_DIGIT_0, ctn_pkg::BYTE_DIGIT_9)));
        else if (roll < 60)
            send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_APOS);
        else if (roll < 72)
        begin
            if ($urandom_range(0, 1))
                send_item(ctn_tb_pkg::KIND_BYTE, 8'h20);
            else
                send_item(ctn_tb_pkg::KIND_BYTE, 8'($urandom_range(0, 8'h2F)));
        end
        else if (roll < 84)
        begin
            send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
            send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
            case ($urandom_range(0, 3))
                0: send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::SQ_LEFT);
                1: send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::SQ_RIGHT);
                2: send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::DQ_LEFT);
                default: send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::DQ_RIGHT);
            endcase
        end
        else if (roll < 90)
        begin
            send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
            if ($urandom_range(0, 1))
                send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
            send_item(ctn_tb_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        end
        else
            send_item(ctn_tb_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // Random messages until about item_goal transactions have gone in
    task automatic run_messages(int item_goal);
        int start;
        start = items_sent;
        while (items_sent - start < item_goal)
        begin
            repeat ($urandom_range(1, 12)) send_token();
            // sometimes leave a prefix open at the end marker
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
                if ($urandom_range(0, 1))
                    send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
            end
            send_item(ctn_tb_pkg::KIND_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // Run timeout
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("chat_text_normalizer_tb failed");
        $finish;
    end

    initial
    begin
        send_idle_pct = 23;
        recv_idle_pct = 49;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: leading separators, case and class boundaries, smart quotes
        send_item(ctn_tb_pkg::KIND_BYTE, 8'h20);
        send_item(ctn_tb_pkg::KIND_BYTE, 8'h00);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_UPPER_A);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_UPPER_Z);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_LOWER_A);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_LOWER_Z);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_DIGIT_0);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_DIGIT_9);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_APOS);
        send_item(ctn_tb_pkg::KIND_BYTE, 8'hFF);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::SQ_LEFT);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::DQ_RIGHT);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_UPPER_Z);
        // broken E2, then broken E2 followed by a fresh prefix
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_UPPER_A);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::SQ_RIGHT);
        // open prefix at the end marker
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_E2);
        send_item(ctn_tb_pkg::KIND_BYTE, ctn_pkg::BYTE_80);
        send_item(ctn_tb_pkg::KIND_END, 8'hFF);
        send_item(ctn_tb_pkg::KIND_END, 8'h00);

        // Empty output limit
        write_limit(16'd0);
        run_messages(12);

        // Largest limit, with a long receiver hold-off while the sender keeps going
        write_limit(16'hFFFF);
        hold_request <= 1'b1;
        run_messages(35);

        // Swapped idling, small limit so messages get cut
        send_idle_pct = 49;
        recv_idle_pct = 23;
        write_limit(16'd7);
        run_messages(35);

        // No idling, tiny limits, with a full pause in the middle
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(16'd3);
        run_messages(18);
        wait_drained();
        write_limit(16'd1);
        run_messages(18);

        wait_drained();
        if (fail_count == 0)
            $display("chat_text_normalizer_tb passed");
        else
            $display("chat_text_normalizer_tb failed");
        $finish;
    end

endmodule
